[design/halton_jitter_generator_defines.svh]
// ----------------------------------------------------------------------------
// Halton jitter generator assertion macros
// Shared property shorthands for the checker that watches the block ports.
// ----------------------------------------------------------------------------
`ifndef HALTON_JITTER_GENERATOR_DEFINES_SVH
`define HALTON_JITTER_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HJG_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HJG_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/hjg_pkg.sv]
// ----------------------------------------------------------------------------
// Halton jitter generator package
// Shared types and fixed constants of the jitter generator.
// ----------------------------------------------------------------------------
package hjg_pkg;

  // Output scaling: results are fixed point with this many fraction bits.
  localparam int unsigned OUT_SCALE_BITS = 30;
  // Quotient bits of the final scale division (magnitude up to 2^30).
  localparam int unsigned SCALE_QUOT_W   = OUT_SCALE_BITS + 1;
  localparam int unsigned CNT_W          = $clog2(SCALE_QUOT_W);
  // Sequence value n+1 spans 1..256.
  localparam int unsigned SEQ_W          = 9;
  // Reversed numerator and b^k denominator (3^6 = 729, 2^9 = 512).
  localparam int unsigned DEN_W          = 10;
  // Screen size registers.
  localparam int unsigned DIM_W          = 15;
  localparam int unsigned JIT_W          = 32;
  localparam int unsigned IDX_W          = 8;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 15'd1920;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 15'd1080;

  // Configuration register indexes.
  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIGIT = 6'b000010,
    S_FRAC  = 6'b000100,
    S_PREP  = 6'b001000,
    S_SCALE = 6'b010000,
    S_DONE  = 6'b100000
  } hjg_state_e;

  // Control of one bit-serial divider.
  typedef struct packed {
    logic load;
    logic step;
  } hjg_div_ctrl_t;

endpackage

[design/hjg_serial_div.sv]
// ----------------------------------------------------------------------------
// Halton jitter generator serial divider
// Restoring divider, one quotient bit per step, remainder kept below divisor.
// ----------------------------------------------------------------------------
module hjg_serial_div import hjg_pkg::*; #(
  parameter int unsigned QUOT_W = 31,
  parameter int unsigned DIVR_W = 15
) (
  input  logic              clk_i,
  input  hjg_div_ctrl_t     ctrl_i,
  input  logic [DIVR_W-1:0] rem_init_i,
  input  logic [QUOT_W-1:0] dividend_i,
  input  logic [DIVR_W-1:0] divisor_i,
  output logic [QUOT_W-1:0] quot_o
);

  logic [DIVR_W-1:0] rem_q, rem_d;
  logic [QUOT_W-1:0] dq_q, dq_d;
  logic [DIVR_W-1:0] divr_q;
  logic [DIVR_W:0]   trial;
  logic [DIVR_W:0]   diff;
  logic              fits;

  // Shift one dividend bit into the partial remainder; the quotient bit
  // fills the vacated low end of the dividend register.
  always_comb begin
    trial = {rem_q, dq_q[QUOT_W-1]};
    diff  = trial - {1'b0, divr_q};
    fits  = (trial >= {1'b0, divr_q});
    rem_d = fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
    dq_d  = {dq_q[QUOT_W-2:0], fits};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rem_q  <= rem_init_i;
      dq_q   <= dividend_i;
      divr_q <= divisor_i;
    end else if (ctrl_i.step) begin
      rem_q  <= rem_d;
      dq_q   <= dq_d;
    end
  end

  assign quot_o = dq_q;

endmodule

[design/halton_jitter_generator.sv]
// ----------------------------------------------------------------------------
// Halton jitter generator
// Sub-pixel jitter from the base 2 / base 3 Halton sequence, digit serial.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one sample index n per
//   beat. The output channel (out_valid_o / out_stall_i) returns one beat
//   per input with jitter_x_o and jitter_y_o, signed, scaled by 2^30.
//   Config: pulse cfg_we_i with cfg_idx_i (0 = width, 1 = height) and
//   cfg_wdata_i; write only while the block is idle. A zero divisor acts as 1.
// Flow:
//   One item at a time. The digit loop splits off one digit of n+1 per
//   cycle in each base (up to 9 digits for base 2); then the fraction
//   divider runs, one state sets up the scale division, the scale divider
//   runs, and the done state loads the output register once it is free.
// Reset: clears the controller and the output valid; width and height
//   return to 1920 and 1080.
// Stall: the output register holds its beat while out_stall_i is high. A
//   new index is accepted meanwhile; its result waits in the done state.
// ----------------------------------------------------------------------------
module halton_jitter_generator import hjg_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 20
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [DIM_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [IDX_W-1:0]        sample_index_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [JIT_W-1:0] jitter_x_o,
  output logic signed [JIT_W-1:0] jitter_y_o
);

  localparam int unsigned MAG_W = FRACTION_BITS + 1;
  localparam logic [CNT_W-1:0] FRAC_LAST  = CNT_W'(FRACTION_BITS - 1);
  localparam logic [CNT_W-1:0] SCALE_LAST = CNT_W'(SCALE_QUOT_W - 1);
  localparam logic [MAG_W-1:0] FIX_ONE    = MAG_W'(1) << FRACTION_BITS;

  hjg_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIM_W-1:0] width_q, height_q;

  // Digit loop registers.
  logic [SEQ_W-1:0] v2_q, v3_q;
  logic [DEN_W-1:0] num2_q, den2_q, num3_q, den3_q;

  logic in_fire;
  logic out_load;
  logic digits_done;

  // Base 3 digit: divide by 3 through the reciprocal 171/512.
  logic [2*SEQ_W-1:0] v3_prod;
  logic [SEQ_W-1:0]   v3_quot;
  logic [SEQ_W:0]     v3_back;
  logic [SEQ_W-1:0]   v3_digit;

  hjg_div_ctrl_t frac_ctrl, scale_ctrl;
  logic [FRACTION_BITS-1:0] h2, h3;
  logic [SCALE_QUOT_W-1:0]  qx, qy;

  logic [MAG_W-1:0] twice_x, twice_y, mag_x, mag_y;
  logic             neg_x_d, neg_y_d, neg_x_q, neg_y_q;
  logic [DIM_W-1:0] div_x, div_y;
  logic [JIT_W-1:0] jx_mag, jy_mag;

  logic             out_valid_q;
  logic [JIT_W-1:0] jitter_x_q, jitter_y_q;

  assign in_fire     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign digits_done = (v2_q == '0) && (v3_q == '0);
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // Configuration writes; an index outside the list cannot occur.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_IDX_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Controller: digits, fraction division, scale division, output.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_DIGIT;
      end
      S_DIGIT: begin
        if (digits_done) begin
          state_d = S_FRAC;
          cnt_d   = '0;
        end
      end
      S_FRAC: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == FRAC_LAST) state_d = S_PREP;
      end
      S_PREP: begin
        state_d = S_SCALE;
        cnt_d   = '0;
      end
      S_SCALE: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == SCALE_LAST) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Split off one digit per cycle for each base and build the reversed
  // numerator and the b^k denominator alongside.
  always_comb begin
    v3_prod  = v3_q * SEQ_W'(171);
    v3_quot  = v3_prod[2*SEQ_W-1:SEQ_W];
    v3_back  = {v3_quot, 1'b0} + {1'b0, v3_quot};
    v3_digit = v3_q - v3_back[SEQ_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      v2_q   <= {1'b0, sample_index_i} + SEQ_W'(1);
      v3_q   <= {1'b0, sample_index_i} + SEQ_W'(1);
      num2_q <= '0;
      den2_q <= DEN_W'(1);
      num3_q <= '0;
      den3_q <= DEN_W'(1);
    end else if (state_q == S_DIGIT) begin
      if (v2_q != '0) begin
        v2_q   <= v2_q >> 1;
        num2_q <= {num2_q[DEN_W-2:0], v2_q[0]};
        den2_q <= {den2_q[DEN_W-2:0], 1'b0};
      end
      if (v3_q != '0) begin
        v3_q   <= v3_quot;
        num3_q <= {num3_q[DEN_W-2:0], 1'b0} + num3_q + DEN_W'(v3_digit[1:0]);
        den3_q <= {den3_q[DEN_W-2:0], 1'b0} + den3_q;
      end
    end
  end

  // Fraction division: h = floor(num * 2^F / b^k), num below b^k.
  assign frac_ctrl.load = (state_q == S_DIGIT) && digits_done;
  assign frac_ctrl.step = (state_q == S_FRAC);

  hjg_serial_div #(
    .QUOT_W(FRACTION_BITS),
    .DIVR_W(DEN_W)
  ) u_frac_x (
    .clk_i     (clk_i),
    .ctrl_i    (frac_ctrl),
    .rem_init_i(num2_q),
    .dividend_i('0),
    .divisor_i (den2_q),
    .quot_o    (h2)
  );

  hjg_serial_div #(
    .QUOT_W(FRACTION_BITS),
    .DIVR_W(DEN_W)
  ) u_frac_y (
    .clk_i     (clk_i),
    .ctrl_i    (frac_ctrl),
    .rem_init_i(num3_q),
    .dividend_i('0),
    .divisor_i (den3_q),
    .quot_o    (h3)
  );

  // Map h to |2h - 1| in fixed point; negative when h is below one half.
  always_comb begin
    twice_x = {h2, 1'b0};
    twice_y = {h3, 1'b0};
    neg_x_d = ~h2[FRACTION_BITS-1];
    neg_y_d = ~h3[FRACTION_BITS-1];
    mag_x   = neg_x_d ? (FIX_ONE - twice_x) : (twice_x - FIX_ONE);
    mag_y   = neg_y_d ? (FIX_ONE - twice_y) : (twice_y - FIX_ONE);
    div_x   = (width_q  == '0) ? DIM_W'(1) : width_q;
    div_y   = (height_q == '0) ? DIM_W'(1) : height_q;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_PREP) begin
      neg_x_q <= neg_x_d;
      neg_y_q <= neg_y_d;
    end
  end

  // Scale division: |2h - 1| * 2^(30-F) / divisor, truncated.
  assign scale_ctrl.load = (state_q == S_PREP);
  assign scale_ctrl.step = (state_q == S_SCALE);

  hjg_serial_div #(
    .QUOT_W(SCALE_QUOT_W),
    .DIVR_W(DIM_W)
  ) u_scale_x (
    .clk_i     (clk_i),
    .ctrl_i    (scale_ctrl),
    .rem_init_i('0),
    .dividend_i(SCALE_QUOT_W'(mag_x) << (OUT_SCALE_BITS - FRACTION_BITS)),
    .divisor_i (div_x),
    .quot_o    (qx)
  );

  hjg_serial_div #(
    .QUOT_W(SCALE_QUOT_W),
    .DIVR_W(DIM_W)
  ) u_scale_y (
    .clk_i     (clk_i),
    .ctrl_i    (scale_ctrl),
    .rem_init_i('0),
    .dividend_i(SCALE_QUOT_W'(mag_y) << (OUT_SCALE_BITS - FRACTION_BITS)),
    .divisor_i (div_y),
    .quot_o    (qy)
  );

  // Restore the sign and hold the beat in the output register.
  assign jx_mag = {1'b0, qx};
  assign jy_mag = {1'b0, qy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      jitter_x_q <= neg_x_q ? (JIT_W'(0) - jx_mag) : jx_mag;
      jitter_y_q <= neg_y_q ? (JIT_W'(0) - jy_mag) : jy_mag;
    end
  end

  assign out_valid_o = out_valid_q;
  assign jitter_x_o  = jitter_x_q;
  assign jitter_y_o  = jitter_y_q;

endmodule

[design/hjg_checker.sv]
// ----------------------------------------------------------------------------
// Halton jitter generator checker
// Port-level assertions on the jitter generator, attached by bind.
// ----------------------------------------------------------------------------
`include "halton_jitter_generator_defines.svh"

module hjg_checker import hjg_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [JIT_W-1:0] jitter_x_o,
  input logic [JIT_W-1:0] jitter_y_o
);

  // One item at a time: the input side closes right after a beat.
  `HJG_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input accepted while an item is in flight")

  // Results stay within plus or minus 2^30; the check rejects values below -2^30.
  `HJG_ASSERT_IMP(a_range, clk_i, rst_ni, out_valid_o, (jitter_x_o[31:30] != 2'b10) && (jitter_y_o[31:30] != 2'b10), "jitter outside its range")

  `HJG_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "output beat dropped under stall")

  `HJG_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(jitter_x_o) && $stable(jitter_y_o), "output payload changed under stall")

endmodule

bind halton_jitter_generator hjg_checker u_hjg_checker (.*);

[tb/tb_halton_jitter_generator.sv]
// ----------------------------------------------------------------------------
// Halton jitter generator testbench
// Sends sample indexes through the valid/stall input channel and holds an
// independent model of the base 2 / base 3 radical inverse, scaled by the
// screen size registers. Every output beat is compared with the oldest
// predicted offset pair. Both channels idle at random. The screen size is
// reprogrammed between phases, including zero and the largest divisors.
// ----------------------------------------------------------------------------
module tb_halton_jitter_generator;
  import hjg_pkg::*;

  localparam int unsigned FRAC_BITS    = 20;
  localparam int unsigned RESET_CYCLES = 8;
  // Give the slowest item some slack at the end.
  localparam int unsigned DRAIN_CYCLES = 80;
  // Longest correct quiet stretch: input gap or output stall plus
  // one item's latency. Take several times that.
  localparam int unsigned QUIET_LIMIT  = 1500;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_ITEMS  = 143;
  localparam int unsigned EDGE_COUNT   = 19;

  typedef struct packed {
    logic [JIT_W-1:0] x;
    logic [JIT_W-1:0] y;
  } offset_pair_t;

  // Indexes whose n+1 sits at or near a digit boundary of either radix, plus 85 and 170.
  localparam logic [IDX_W-1:0] EDGE_INDEXES [EDGE_COUNT] = '{
    8'd0, 8'd1, 8'd2, 8'd3, 8'd7, 8'd8, 8'd15, 8'd26, 8'd63, 8'd64,
    8'd80, 8'd85, 8'd127, 8'd128, 8'd170, 8'd241, 8'd242, 8'd254, 8'd255
  };

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic                    cfg_idx_i;
  logic [DIM_W-1:0]        cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [IDX_W-1:0]        sample_index_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [JIT_W-1:0] jitter_x_o;
  logic signed [JIT_W-1:0] jitter_y_o;

  // Indexes waiting to be sent, and offsets waiting to come back.
  logic [IDX_W-1:0] index_backlog [$];
  offset_pair_t     offset_queue  [$];

  // Model copy of the screen size registers.
  logic [DIM_W-1:0] width_copy;
  logic [DIM_W-1:0] height_copy;

  int unsigned mismatches;
  int unsigned send_gap;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  bit          send_calm;
  bit          hold_calm;
  bit          in_taken;

  halton_jitter_generator #(
    .FRACTION_BITS (FRAC_BITS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_index_i (sample_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .jitter_x_o     (jitter_x_o),
    .jitter_y_o     (jitter_y_o)
  );

  always #6 clk_i = ~clk_i;

  // Radical inverse of pos in the given radix, truncated to FRAC_BITS,
  // mapped to 2h-1, divided by the screen size and scaled by 2^30.
  // Round toward zero: divide the magnitude, then restore the sign.
  function automatic logic [JIT_W-1:0] jitter_for(input logic [SEQ_W-1:0] pos,
                                                  input int unsigned radix,
                                                  input logic [DIM_W-1:0] dim);
    logic [63:0]      reversed;
    logic [63:0]      radix_pow;
    logic [63:0]      frac;
    logic [63:0]      twice;
    logic [63:0]      mag;
    logic [63:0]      divisor;
    logic [SEQ_W-1:0] rest;
    logic             neg;
    logic [JIT_W-1:0] r;
    reversed  = '0;
    radix_pow = 64'd1;
    rest      = pos;
    while (rest != 0) begin
      reversed  = reversed * radix + (rest % radix);
      radix_pow = radix_pow * radix;
      rest      = SEQ_W'(rest / radix);
    end
    frac    = (reversed << FRAC_BITS) / radix_pow;
    twice   = frac * 2;
    neg     = twice < (64'd1 << FRAC_BITS);
    mag     = neg ? ((64'd1 << FRAC_BITS) - twice) : (twice - (64'd1 << FRAC_BITS));
    // A zero register acts as a divisor of one.
    divisor = (dim == '0) ? 64'd1 : 64'(dim);
    mag     = (mag << (OUT_SCALE_BITS - FRAC_BITS)) / divisor;
    r       = mag[JIT_W-1:0];
    if (neg) begin
      r = -r;
    end
    return r;
  endfunction

  // Idle length: mostly none or short, a few long; none at all while calm.
  function automatic int unsigned pick_pause(input bit calm);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 50) begin
      return 0;
    end
    if (roll < 85) begin
      return $urandom_range(1, 3);
    end
    if (roll < 97) begin
      return $urandom_range(4, 15);
    end
    return $urandom_range(30, 120);
  endfunction

  // Random index: uniform, a host walking a 16-entry table, or an extreme.
  function automatic logic [IDX_W-1:0] pick_index(inout int unsigned walk);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) begin
      return IDX_W'($urandom_range(0, 255));
    end
    if (roll < 8) begin
      walk = (walk + 1) % 16;
      return IDX_W'(walk);
    end
    return (roll == 8) ? '0 : '1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatches++;
  endtask

  // Drive one register write for a single cycle.
  task automatic write_reg(input logic idx, input logic [DIM_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Append one index to the send backlog.
  task automatic queue_index(input logic [IDX_W-1:0] idx);
    index_backlog = {index_backlog, idx};
  endtask

  // Block until every queued index is sent and every offset is back.
  task automatic wait_drained();
    while (index_backlog.size() != 0 || in_valid_i || offset_queue.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Input driver: present the next index once the current beat is taken,
  // inserting a random gap after each beat.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (send_gap != 0) begin
        send_gap = send_gap - 1;
        in_valid_i <= 1'b0;
      end else if (index_backlog.size() != 0) begin
        sample_index_i <= index_backlog.pop_front();
        in_valid_i     <= 1'b1;
        send_gap = pick_pause(send_calm);
        if ($urandom_range(0, 63) == 0) begin
          send_calm = !send_calm;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output stall driver: stall stretches of random length, free of any
  // dependence on out_valid_o.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        hold_left = pick_pause(hold_calm);
        out_stall_i <= 1'b0;
        if ($urandom_range(0, 63) == 0) begin
          hold_calm = !hold_calm;
        end
      end
    end
  end

  // Monitor: check the output beat against the oldest prediction first,
  // then predict for an input beat taken at this same edge.
  always @(posedge clk_i) begin
    offset_pair_t     want;
    logic [SEQ_W-1:0] pos;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (offset_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected beat x=%0d y=%0d", jitter_x_o, jitter_y_o));
        end else begin
          want = offset_queue.pop_front();
          if (jitter_x_o !== want.x) begin
            report_mismatch($sformatf("jitter_x got %0d want %0d",
                                      jitter_x_o, $signed(want.x)));
          end
          if (jitter_y_o !== want.y) begin
            report_mismatch($sformatf("jitter_y got %0d want %0d",
                                      jitter_y_o, $signed(want.y)));
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        pos    = SEQ_W'(sample_index_i) + 1'b1;
        want.x = jitter_for(pos, 2, width_copy);
        want.y = jitter_for(pos, 3, height_copy);
        offset_queue = {offset_queue, want};
      end
      // Track register writes in the model copy.
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_IDX_WIDTH) begin
          width_copy = cfg_wdata_i;
        end else begin
          height_copy = cfg_wdata_i;
        end
      end
      in_taken <= in_valid_i && !in_stall_o;
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("halton_jitter_generator verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    // Screen sizes per phase: zero, one, the largest values, mixed shapes.
    logic [DIM_W-1:0] phase_width  [8];
    logic [DIM_W-1:0] phase_height [8];
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    int unsigned      walk;
    phase_width  = '{15'd0, 15'd1, 15'd32767, 15'd16384, 15'd1, 15'd32767, 15'd3, 15'd16385};
    phase_height = '{15'd0, 15'd1, 15'd32767, 15'd16384, 15'd32767, 15'd1, 15'd7, 15'd2};
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_IDX_WIDTH;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    sample_index_i = '0;
    out_stall_i    = 1'b0;
    width_copy     = WIDTH_RST;
    height_copy    = HEIGHT_RST;
    mismatches     = 0;
    send_gap       = 0;
    hold_left      = 0;
    quiet_cycles   = 0;
    send_calm      = 1'b0;
    hold_calm      = 1'b0;
    walk           = 0;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats at the reset screen size: digit boundaries and extremes.
    foreach (EDGE_INDEXES[i]) begin
      queue_index(EDGE_INDEXES[i]);
    end
    wait_drained();

    // Random phases, each under its own screen size.
    for (int p = 0; p < PHASES; p++) begin
      if (p < 8) begin
        w = phase_width[p];
        h = phase_height[p];
      end else begin
        w = DIM_W'($urandom_range(1, 32767));
        h = DIM_W'($urandom_range(1, 32767));
      end
      write_reg(CFG_IDX_WIDTH, w);
      write_reg(CFG_IDX_HEIGHT, h);
      queue_index('0);
      queue_index('1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        queue_index(pick_index(walk));
      end
      wait_drained();
    end

    // Let any stray beat show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (offset_queue.size() != 0) begin
      report_mismatch($sformatf("%0d offsets never arrived", offset_queue.size()));
    end
    if (mismatches == 0) begin
      $display("halton_jitter_generator verification clean");
    end else begin
      $display("halton_jitter_generator verification failed");
    end
    $finish;
  end

endmodule
